/* rtl/ftse_pkg.sv */
`default_nettype none
package ftse_pkg;

    localparam int DEF_MAX_ENTRIES = 1024;
    localparam int CFG_W = 11;
    localparam int IN_IDX_W = 11;
    localparam int DATA_W = 32;
    localparam int ACTIVE_SIZE_RESET = 1024;

    typedef enum logic [1:0] {
        REQ_POINT_ADD = 2'd0,
        REQ_RANGE_ADD = 2'd1,
        REQ_PREFIX_SUM = 2'd2,
        REQ_RANGE_SUM = 2'd3
    } req_kind_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] sum;
        logic                     clamped;
    } res_t;

endpackage
`default_nettype wire

/* rtl/ftse_ifs.sv */
`default_nettype none
interface ftse_req_if
    import ftse_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [1:0]               req_type;
    logic [IN_IDX_W-1:0]      left_index;
    logic [IN_IDX_W-1:0]      right_index;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output req_type, output left_index,
                    output right_index, output value, input ready);
    modport sink (input valid, input req_type, input left_index,
                  input right_index, input value, output ready);
endinterface

interface ftse_res_if
    import ftse_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] sum;
    logic                     clamped;

    modport source (output valid, output sum, output clamped, input ready);
    modport sink (input valid, input sum, input clamped, output ready);
endinterface
`default_nettype wire

/* rtl/fenwick_tree_sum_engine_core.sv */
// walk: one tree memory read per entry visited on each index chain, then the flush
// and emit states; the result waits in the emit state until the output register takes it
// throughput: one request at a time, set by the single read port of the tree memory
// and its registered read; a new request enters while the last result waits in the output register
// reset: asynchronous, active low; afterwards a clearing pass writes zero to all
// MAX_ENTRIES+1 entries before the first request is taken
`default_nettype none
module fenwick_tree_sum_engine_core
    import ftse_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             cfg_we,
    input  wire logic [CFG_W-1:0] cfg_wdata,
    ftse_req_if.sink              req,
    ftse_res_if.source            res
);

    localparam int IDX_W = $clog2(MAX_ENTRIES + 1);
    localparam int CW = (IDX_W + 1 > IN_IDX_W + 1) ? IDX_W + 1 : IN_IDX_W + 1;
    localparam logic [CW-1:0] MAX_N = CW'(MAX_ENTRIES);
    localparam logic [CW-1:0] EFF_RESET =
        (ACTIVE_SIZE_RESET > MAX_ENTRIES) ? CW'(MAX_ENTRIES) : CW'(ACTIVE_SIZE_RESET);

    logic [CW-1:0]     eff_n_reg;
    logic [CW-1:0]     cfg_ext;
    logic              out_valid_reg;
    res_t              out_data_reg;
    logic              walk_valid;
    logic              walk_ready;
    res_t              walk_data;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    logic [DATA_W-1:0] ram_rdata;
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [DATA_W-1:0] ram_wdata;

    assign cfg_ext = CW'(cfg_wdata);

    // sizes above capacity saturate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eff_n_reg <= EFF_RESET;
        end
        else if (cfg_we)
        begin
            eff_n_reg <= (cfg_ext > MAX_N) ? MAX_N : cfg_ext;
        end
    end

    assign walk_ready = !out_valid_reg || res.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (walk_ready)
        begin
            out_valid_reg <= walk_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (walk_ready && walk_valid)
        begin
            out_data_reg <= walk_data;
        end
    end

    assign res.valid   = out_valid_reg;
    assign res.sum     = out_data_reg.sum;
    assign res.clamped = out_data_reg.clamped;

    ftse_ram #(
        .DEPTH (MAX_ENTRIES + 1)
    ) u_ram (
        .clk   (clk),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata)
    );

    ftse_walk #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .eff_n     (eff_n_reg),
        .req       (req),
        .res_valid (walk_valid),
        .res_ready (walk_ready),
        .res_data  (walk_data),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata)
    );

endmodule
`default_nettype wire

/* rtl/ftse_ram.sv */
`default_nettype none
module ftse_ram
    import ftse_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_ENTRIES + 1,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic              clk,
    input  wire logic              re,
    input  wire logic [AW-1:0]     raddr,
    output logic      [DATA_W-1:0] rdata,
    input  wire logic              we,
    input  wire logic [AW-1:0]     waddr,
    input  wire logic [DATA_W-1:0] wdata
);

    logic [DATA_W-1:0] mem [DEPTH];
    logic [DATA_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // same-cycle write to the read address is forwarded
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            if (we && (waddr == raddr))
            begin
                rdata_reg <= wdata;
            end
            else
            begin
                rdata_reg <= mem[raddr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

/* rtl/ftse_walk.sv */
`default_nettype none
module ftse_walk
    import ftse_pkg::*;
#(
    parameter int MAX_ENTRIES = DEF_MAX_ENTRIES,
    localparam int IDX_W = $clog2(MAX_ENTRIES + 1),
    localparam int CW = (IDX_W + 1 > IN_IDX_W + 1) ? IDX_W + 1 : IN_IDX_W + 1
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic [CW-1:0]     eff_n,
    ftse_req_if.sink               req,
    output logic                   res_valid,
    input  wire logic              res_ready,
    output res_t                   res_data,
    output logic                   ram_re,
    output logic      [IDX_W-1:0]  ram_raddr,
    input  wire logic [DATA_W-1:0] ram_rdata,
    output logic                   ram_we,
    output logic      [IDX_W-1:0]  ram_waddr,
    output logic      [DATA_W-1:0] ram_wdata
);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_WALK  = 5'b00100,
        ST_FLUSH = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    localparam logic [IDX_W-1:0] LAST_ADDR = IDX_W'(MAX_ENTRIES);

    state_t            state_reg, state_next;
    logic [IDX_W-1:0]  clr_cnt_reg, clr_cnt_next;
    req_kind_t         kind_reg, kind_next;
    logic              upd_reg, upd_next;
    logic [IN_IDX_W-1:0] left_reg, left_next;
    logic [IN_IDX_W-1:0] right_reg, right_next;
    logic [DATA_W-1:0] val_reg, val_next;
    logic [DATA_W-1:0] nval_reg, nval_next;
    logic              chain_reg, chain_next;
    logic              neg_reg, neg_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic              clamp_reg, clamp_next;
    logic [DATA_W-1:0] acc_reg, acc_next;
    logic              pend_valid_reg, pend_valid_next;
    logic              pend_neg_reg, pend_neg_next;
    logic [IDX_W-1:0]  pend_addr_reg, pend_addr_next;

    logic          accept;
    logic          run;
    logic          need_second;
    logic [CW-1:0] lowbit;
    logic [CW-1:0] start;
    logic          start_upd;

    assign accept = req.valid && req.ready;
    assign req.ready = (state_reg == ST_IDLE);

    assign run = upd_reg ? ((idx_reg != '0) && (idx_reg <= eff_n)) : (idx_reg != '0);
    assign lowbit = idx_reg & (~idx_reg + CW'(1));
    assign need_second = (kind_reg == REQ_RANGE_ADD) ||
                         ((kind_reg == REQ_RANGE_SUM) && (left_reg != '0));

    assign res_valid = (state_reg == ST_EMIT);
    assign res_data.sum = $signed(acc_reg);
    assign res_data.clamped = clamp_reg;

    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        kind_next       = kind_reg;
        upd_next        = upd_reg;
        left_next       = left_reg;
        right_next      = right_reg;
        val_next        = val_reg;
        nval_next       = nval_reg;
        chain_next      = chain_reg;
        neg_next        = neg_reg;
        idx_next        = idx_reg;
        clamp_next      = clamp_reg;
        acc_next        = acc_reg;
        pend_valid_next = 1'b0;
        pend_neg_next   = pend_neg_reg;
        pend_addr_next  = pend_addr_reg;
        ram_re          = 1'b0;
        ram_raddr       = idx_reg[IDX_W-1:0];
        ram_we          = 1'b0;
        ram_waddr       = pend_addr_reg;
        ram_wdata       = ram_rdata + (pend_neg_reg ? nval_reg : val_reg);
        start           = '0;
        start_upd       = 1'b0;

        // read data of last cycle's access: write back or accumulate
        if (pend_valid_reg)
        begin
            if (upd_reg)
            begin
                ram_we = 1'b1;
            end
            else if (pend_neg_reg)
            begin
                acc_next = acc_reg - ram_rdata;
            end
            else
            begin
                acc_next = acc_reg + ram_rdata;
            end
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
                clr_cnt_next = clr_cnt_reg + IDX_W'(1);
                if (clr_cnt_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    kind_next  = req_kind_t'(req.req_type);
                    left_next  = req.left_index;
                    right_next = req.right_index;
                    val_next   = $unsigned(req.value);
                    nval_next  = '0 - $unsigned(req.value);
                    chain_next = 1'b0;
                    neg_next   = 1'b0;
                    acc_next   = '0;
                    clamp_next = 1'b0;
                    start_upd  = (req.req_type == REQ_POINT_ADD) ||
                                 (req.req_type == REQ_RANGE_ADD);
                    upd_next   = start_upd;
                    start      = (req.req_type == REQ_RANGE_SUM) ?
                                 CW'(req.right_index) : CW'(req.left_index);
                    idx_next   = start;
                    if (!start_upd && (start > eff_n))
                    begin
                        idx_next   = eff_n;
                        clamp_next = 1'b1;
                    end
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (run)
                begin
                    ram_re          = 1'b1;
                    pend_valid_next = 1'b1;
                    pend_neg_next   = neg_reg;
                    pend_addr_next  = idx_reg[IDX_W-1:0];
                    idx_next        = upd_reg ? (idx_reg + lowbit) : (idx_reg - lowbit);
                end
                else if (!chain_reg && need_second)
                begin
                    chain_next = 1'b1;
                    neg_next   = 1'b1;
                    if (upd_reg)
                    begin
                        idx_next = CW'(right_reg) + CW'(1);
                    end
                    else
                    begin
                        start = CW'(left_reg) - CW'(1);
                        idx_next = start;
                        if (start > eff_n)
                        begin
                            idx_next   = eff_n;
                            clamp_next = 1'b1;
                        end
                    end
                end
                else
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg      <= kind_next;
        upd_reg       <= upd_next;
        left_reg      <= left_next;
        right_reg     <= right_next;
        val_reg       <= val_next;
        nval_reg      <= nval_next;
        chain_reg     <= chain_next;
        neg_reg       <= neg_next;
        idx_reg       <= idx_next;
        clamp_reg     <= clamp_next;
        acc_reg       <= acc_next;
        pend_neg_reg  <= pend_neg_next;
        pend_addr_reg <= pend_addr_next;
    end

    a_no_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) || (state_reg == ST_EMIT) |-> !pend_valid_reg)
        else $error("read still in flight outside the walk");

    a_wb_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg && upd_reg |-> (CW'(pend_addr_reg) <= eff_n) && (pend_addr_reg != '0))
        else $error("write back outside active entries");

    a_add_result: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && upd_reg |-> (acc_reg == '0) && !clamp_reg)
        else $error("add request produced a nonzero result");

    a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_WALK) && !pend_valid_reg)
        else $error("accepted transfer did not start a walk");

endmodule
`default_nettype wire

/* tb/sv/tb.sv */
module tb;
    import ftse_pkg::*;

    localparam int TREE_ENTRIES = DEF_MAX_ENTRIES;
    localparam int IDX_TOP = (1 << IN_IDX_W) - 1;
    localparam int DRAIN_LIMIT = 20000;

    // mirror of the tree store and of the size register, plus the results still owed
    class bit_tree_tracker;
        bit [DATA_W-1:0] node_total [0:TREE_ENTRIES];
        int unsigned     size_reg;
        res_t            expected_sums [$];
        int unsigned     mismatches;

        function new();
            foreach (node_total[k])
                node_total[k] = '0;
            size_reg = ACTIVE_SIZE_RESET;
            mismatches = 0;
        endfunction

        function int unsigned live_entries();
            return (size_reg > TREE_ENTRIES) ? TREE_ENTRIES : size_reg;
        endfunction

        function void add_at(int unsigned idx, bit [DATA_W-1:0] amt);
            int unsigned n;
            n = live_entries();
            if (idx == 0)
                return;
            while (idx <= n)
            begin
                node_total[idx] += amt;
                idx += idx & (~idx + 1);
            end
        endfunction

        function bit [DATA_W-1:0] prefix_total(int unsigned idx, inout bit clip);
            int unsigned     n;
            bit [DATA_W-1:0] acc;
            n = live_entries();
            acc = '0;
            if (idx > n)
            begin
                idx = n;
                clip = 1'b1;
            end
            while (idx >= 1)
            begin
                acc += node_total[idx];
                idx -= idx & (~idx + 1);
            end
            return acc;
        endfunction

        function void note_request(req_kind_t kind, int unsigned lo, int unsigned hi,
                                   bit [DATA_W-1:0] amt);
            res_t            want;
            bit              clip;
            bit [DATA_W-1:0] upper;
            bit [DATA_W-1:0] lower;
            clip = 1'b0;
            want.sum = '0;
            case (kind)
                REQ_POINT_ADD:
                    add_at(lo, amt);
                REQ_RANGE_ADD:
                begin
                    add_at(lo, amt);
                    add_at(hi + 1, '0 - amt);
                end
                REQ_PREFIX_SUM:
                    want.sum = prefix_total(lo, clip);
                default:
                begin
                    upper = prefix_total(hi, clip);
                    if (lo == 0)
                        lower = '0;
                    else
                        lower = prefix_total(lo - 1, clip);
                    want.sum = upper - lower;
                end
            endcase
            want.clamped = clip;
            expected_sums.push_back(want);
        endfunction

        function void check_result(logic [DATA_W-1:0] got_sum, logic got_clamped);
            res_t want;
            if (expected_sums.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: sum %h clamped %b", got_sum, got_clamped);
                return;
            end
            want = expected_sums.pop_front();
            if (got_sum !== want.sum || got_clamped !== want.clamped)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result mismatch: sum exp %h got %h, clamped exp %b got %b",
                             want.sum, got_sum, want.clamped, got_clamped);
            end
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;

    ftse_req_if req_ch ();
    ftse_res_if res_ch ();

    bit_tree_tracker tree_track = new();
    bit              tx_idle;
    bit              rx_idle;
    int unsigned     hold_cycles;

    fenwick_tree_sum_engine_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .req       (req_ch),
        .res       (res_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #5_000_000;
        $display("tb NOT OK");
        $finish;
    end

    // result side: check each transfer, then decide ready for the next edge
    initial
    begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1)
                tree_track.check_result(res_ch.sum, res_ch.clamped);
            if (hold_cycles != 0)
            begin
                stall_left = hold_cycles;
                hold_cycles = 0;
            end
            if (stall_left != 0)
            begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (rx_idle && $urandom_range(0, 5) == 0)
            begin
                res_ch.ready <= 1'b0;
                stall_left = $urandom_range(0, 5);
            end
            else
                res_ch.ready <= 1'b1;
        end
    end

    // returns at the edge of the transfer with valid still high
    task automatic issue_request(input req_kind_t kind, input logic [IN_IDX_W-1:0] lo,
                                 input logic [IN_IDX_W-1:0] hi, input logic [DATA_W-1:0] amt);
        int unsigned gap;
        gap = (tx_idle && $urandom_range(0, 4) == 0) ? $urandom_range(1, 6) : 0;
        if (gap != 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.left_index <= lo;
        req_ch.right_index <= hi;
        req_ch.value <= amt;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        tree_track.note_request(kind, lo, hi, amt);
    endtask

    task automatic drain_results();
        int unsigned waited;
        req_ch.valid <= 1'b0;
        waited = 0;
        while (tree_track.expected_sums.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic resize_tree(input logic [CFG_W-1:0] sz);
        drain_results();
        cfg_we <= 1'b1;
        cfg_wdata <= sz;
        @(posedge clk);
        cfg_we <= 1'b0;
        tree_track.size_reg = sz;
    endtask

    // mostly in range, some just past the size, a few anywhere in the field
    function automatic logic [IN_IDX_W-1:0] pick_index(int unsigned n);
        case ($urandom_range(0, 9))
            0: return IN_IDX_W'($urandom_range(0, IDX_TOP));
            1: return IN_IDX_W'(n + 1);
            2: return IN_IDX_W'(n);
            default: return IN_IDX_W'($urandom_range(0, n));
        endcase
    endfunction

    task automatic random_burst(input int unsigned count);
        req_kind_t            kind;
        logic [IN_IDX_W-1:0]  lo;
        logic [IN_IDX_W-1:0]  hi;
        logic [IN_IDX_W-1:0]  swap;
        logic [DATA_W-1:0]    amt;
        int unsigned          n;
        repeat (count)
        begin
            n = tree_track.live_entries();
            kind = req_kind_t'($urandom_range(0, 3));
            lo = pick_index(n);
            hi = pick_index(n);
            if (kind == REQ_RANGE_SUM && lo > hi && $urandom_range(0, 3) != 0)
            begin
                swap = lo;
                lo = hi;
                hi = swap;
            end
            case ($urandom_range(0, 9))
                0: amt = 32'h8000_0000;
                1: amt = 32'h7fff_ffff;
                2, 3: amt = $urandom_range(0, 31) - 16;
                default: amt = $urandom;
            endcase
            issue_request(kind, lo, hi, amt);
        end
    endtask

    initial
    begin
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        hold_cycles = 0;
        rst_n <= 1'b0;
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        req_ch.valid <= 1'b0;
        req_ch.req_type <= REQ_POINT_ADD;
        req_ch.left_index <= '0;
        req_ch.right_index <= '0;
        req_ch.value <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full size after reset: edges of the index and value fields
        issue_request(REQ_PREFIX_SUM, 0, 0, 0);
        issue_request(REQ_POINT_ADD, 1, 0, 32'h7fff_ffff);
        issue_request(REQ_POINT_ADD, 1024, 0, 32'h8000_0000);
        issue_request(REQ_POINT_ADD, 0, 0, 32'hffff_ffff);
        issue_request(REQ_POINT_ADD, 2047, 2047, 32'h5555_5555);
        issue_request(REQ_RANGE_ADD, 3, 1024, 32'haaaa_aaaa);
        issue_request(REQ_RANGE_ADD, 10, 5, 7);
        issue_request(REQ_RANGE_ADD, 0, 5, 32'hffff_ffff);
        issue_request(REQ_PREFIX_SUM, 1024, 0, 0);
        issue_request(REQ_PREFIX_SUM, 2047, 0, 0);
        issue_request(REQ_PREFIX_SUM, 512, 0, 0);
        issue_request(REQ_RANGE_SUM, 0, 1024, 0);
        issue_request(REQ_RANGE_SUM, 20, 3, 0);
        issue_request(REQ_RANGE_SUM, 1026, 4, 0);
        issue_request(REQ_RANGE_SUM, 2047, 2047, 0);
        issue_request(REQ_RANGE_SUM, 1, 1, 0);

        // empty tree: updates dropped, positive query indices clamp to zero
        resize_tree(0);
        issue_request(REQ_POINT_ADD, 1, 0, 5);
        issue_request(REQ_PREFIX_SUM, 1, 0, 0);
        issue_request(REQ_RANGE_SUM, 0, 0, 0);
        issue_request(REQ_RANGE_ADD, 1, 0, 3);

        // size register above capacity
        resize_tree(2047);
        issue_request(REQ_PREFIX_SUM, 2047, 0, 0);
        issue_request(REQ_POINT_ADD, 1024, 0, 1);
        issue_request(REQ_RANGE_SUM, 1, 1024, 0);

        resize_tree(1);
        issue_request(REQ_RANGE_ADD, 1, 1, 9);
        issue_request(REQ_RANGE_SUM, 2, 1, 0);

        // long receiver hold-off while requests keep coming
        resize_tree(1024);
        hold_cycles = 300;
        random_burst(250);
        resize_tree(16);
        random_burst(150);
        resize_tree(1);
        random_burst(100);
        resize_tree(0);
        random_burst(60);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        resize_tree(2047);
        random_burst(200);
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        resize_tree(2);
        random_burst(100);
        resize_tree(700);
        random_burst(150);
        resize_tree(CFG_W'($urandom_range(3, 1023)));
        random_burst(200);
        resize_tree(1023);
        random_burst(150);
        tx_idle = 1'b0;
        rx_idle = 1'b0;
        resize_tree(1024);
        random_burst(250);

        drain_results();
        repeat (30) @(posedge clk);
        if (tree_track.mismatches == 0 && tree_track.expected_sums.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
